// ===== rtl/core/fwcrc_pkg.sv =====
// Shared types, constants and CRC-32 table for the firmware image CRC verifier.
// No dependencies; every other file of the block imports this package.
package fwcrc_pkg;

    localparam int unsigned REGION_BYTES = 65536;
    // The byte counter must be able to hold the region size itself.
    localparam int          CNT_W        = $clog2(REGION_BYTES + 1);
    localparam logic [31:0] REGION_LIMIT = 32'(REGION_BYTES);

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_NO_REQUEST = 2'd0,
        ST_SIZE_ERROR = 2'd1,
        ST_CRC_FAIL   = 2'd2,
        ST_OK         = 2'd3
    } status_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [31:0] header_magic;
        logic [31:0] image_size;
        logic [31:0] expected_crc;
        logic [7:0]  data_byte;
    } item_t;

    typedef logic [31:0] crc_table_t [256];

    // Builds the byte-wise table of the reflected CRC-32 at elaboration.
    function automatic crc_table_t crc_table_gen();
        crc_table_t  tbl;
        logic [31:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 32'(i);
            for (int k = 0; k < 8; k++) begin
                if (c[0]) begin
                    c = (c >> 1) ^ CRC_POLY;
                end
                else begin
                    c = c >> 1;
                end
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam crc_table_t CRC_TABLE = crc_table_gen();

    function automatic logic [31:0] crc_update(logic [31:0] crc, logic [7:0] b);
        logic [7:0] idx;
        idx = crc[7:0] ^ b;
        return {8'h00, crc[31:8]} ^ CRC_TABLE[idx];
    endfunction

endpackage

// ===== rtl/core/fwcrc_in_if.sv =====
// Request channel of the verifier: valid/ready handshake with header and data fields.
// Depends on fwcrc_pkg.
interface fwcrc_in_if;
    import fwcrc_pkg::*;

    logic        valid;
    logic        ready;
    opcode_t     opcode;
    logic [31:0] header_magic;
    logic [31:0] image_size;
    logic [31:0] expected_crc;
    logic [7:0]  data_byte;

    modport source (
        output valid, opcode, header_magic, image_size, expected_crc, data_byte,
        input  ready
    );

    modport sink (
        input  valid, opcode, header_magic, image_size, expected_crc, data_byte,
        output ready
    );
endinterface

// ===== rtl/core/fwcrc_out_if.sv =====
// Result channel of the verifier: valid/ready handshake with the verdict fields.
// Depends on fwcrc_pkg.
interface fwcrc_out_if;
    import fwcrc_pkg::*;

    logic        valid;
    logic        ready;
    status_t     status;
    logic        discard_header;
    logic [31:0] computed_crc;

    modport source (
        output valid, status, discard_header, computed_crc,
        input  ready
    );

    modport sink (
        input  valid, status, discard_header, computed_crc,
        output ready
    );
endinterface

// ===== rtl/core/fwcrc_in_stage.sv =====
// Input register of the verifier: captures one request and holds it for the core.
// Depends on fwcrc_pkg and fwcrc_in_if.
module fwcrc_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    fwcrc_in_if.sink         item,
    input  logic             advance,
    output logic             s1_valid,
    output fwcrc_pkg::item_t s1_item
);
    import fwcrc_pkg::*;

    logic  s1_valid_reg;
    logic  s1_valid_next;
    item_t s1_item_reg;
    logic  accept;

    // The register can take a new request whenever its current one moves on.
    assign item.ready = !s1_valid_reg || advance;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.opcode       <= item.opcode;
            s1_item_reg.header_magic <= item.header_magic;
            s1_item_reg.image_size   <= item.image_size;
            s1_item_reg.expected_crc <= item.expected_crc;
            s1_item_reg.data_byte    <= item.data_byte;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;
endmodule

// ===== rtl/core/fwcrc_core.sv =====
// Verification core: header checks, table-driven CRC-32 update, byte count and
// the result register. Depends on fwcrc_pkg and fwcrc_out_if.
module fwcrc_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s1_valid,
    input  fwcrc_pkg::item_t s1_item,
    input  logic [31:0]      required_magic,
    output logic             advance,
    fwcrc_out_if.source      verdict
);
    import fwcrc_pkg::*;

    logic             armed_reg;
    logic             armed_next;
    logic [31:0]      crc_acc_reg;
    logic [31:0]      crc_acc_next;
    logic [CNT_W-1:0] bytes_seen_reg;
    logic [CNT_W-1:0] bytes_seen_next;
    logic [CNT_W-1:0] stored_size_reg;
    logic [CNT_W-1:0] stored_size_next;
    logic [31:0]      stored_expected_reg;
    logic [31:0]      stored_expected_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    status_t          status_reg;
    status_t          status_next;
    logic             discard_reg;
    logic             discard_next;
    logic [31:0]      crc_out_reg;
    logic [31:0]      crc_out_next;

    logic             fire;
    logic             emit;
    logic [31:0]      crc_new;
    logic [31:0]      crc_final;

    // A request leaves the input register once the result register is free.
    assign advance   = !out_valid_reg || verdict.ready;
    assign fire      = s1_valid && advance;
    assign crc_new   = crc_update(crc_acc_reg, s1_item.data_byte);
    assign crc_final = crc_new ^ CRC_ALL_ONES;

    always_comb
    begin
        armed_next           = armed_reg;
        crc_acc_next         = crc_acc_reg;
        bytes_seen_next      = bytes_seen_reg;
        stored_size_next     = stored_size_reg;
        stored_expected_next = stored_expected_reg;
        emit                 = 1'b0;
        status_next          = status_reg;
        discard_next         = discard_reg;
        crc_out_next         = crc_out_reg;

        if (fire)
        begin
            case (s1_item.opcode)
                OP_START:
                begin
                    // A new header always abandons any check in progress.
                    armed_next = 1'b0;
                    if (s1_item.header_magic != required_magic)
                    begin
                        emit         = 1'b1;
                        status_next  = ST_NO_REQUEST;
                        discard_next = 1'b0;
                        crc_out_next = '0;
                    end
                    else if (s1_item.image_size == '0 || s1_item.image_size > REGION_LIMIT)
                    begin
                        emit         = 1'b1;
                        status_next  = ST_SIZE_ERROR;
                        discard_next = 1'b0;
                        crc_out_next = '0;
                    end
                    else
                    begin
                        armed_next           = 1'b1;
                        crc_acc_next         = CRC_ALL_ONES;
                        bytes_seen_next      = '0;
                        stored_size_next     = s1_item.image_size[CNT_W-1:0];
                        stored_expected_next = s1_item.expected_crc;
                    end
                end
                OP_DATA:
                begin
                    if (armed_reg)
                    begin
                        crc_acc_next    = crc_new;
                        bytes_seen_next = bytes_seen_reg + CNT_W'(1);
                        if (bytes_seen_next >= stored_size_reg)
                        begin
                            armed_next   = 1'b0;
                            emit         = 1'b1;
                            crc_out_next = crc_final;
                            if (crc_final == stored_expected_reg)
                            begin
                                status_next  = ST_OK;
                                discard_next = 1'b0;
                            end
                            else
                            begin
                                status_next  = ST_CRC_FAIL;
                                discard_next = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    armed_next = armed_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (verdict.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg           <= 1'b0;
            crc_acc_reg         <= CRC_ALL_ONES;
            bytes_seen_reg      <= '0;
            stored_size_reg     <= '0;
            stored_expected_reg <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            armed_reg           <= armed_next;
            crc_acc_reg         <= crc_acc_next;
            bytes_seen_reg      <= bytes_seen_next;
            stored_size_reg     <= stored_size_next;
            stored_expected_reg <= stored_expected_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg  <= status_next;
            discard_reg <= discard_next;
            crc_out_reg <= crc_out_next;
        end
    end

    assign verdict.valid          = out_valid_reg;
    assign verdict.status         = status_reg;
    assign verdict.discard_header = discard_reg;
    assign verdict.computed_crc   = crc_out_reg;
endmodule

// ===== rtl/core/firmware_image_crc_verifier.sv =====
// Firmware image CRC verifier, top level.
// The input register captures a request; the result register takes its verdict once
// it is empty or its verdict is being taken. One request a cycle is sustained while
// that holds; each data byte gets a table-driven CRC byte update as it moves on.
// Reset (rst_n, asynchronous, active low) clears the handshakes, disarms the check and
// sets required_magic to zero; there is no clearing pass.
module firmware_image_crc_verifier (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    fwcrc_in_if.sink    item,
    fwcrc_out_if.source verdict
);
    import fwcrc_pkg::*;

    logic [31:0] magic_reg;
    logic        advance;
    logic        s1_valid;
    item_t       s1_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            magic_reg <= cfg_wr_data;
        end
    end

    fwcrc_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    fwcrc_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .s1_valid       (s1_valid),
        .s1_item        (s1_item),
        .required_magic (magic_reg),
        .advance        (advance),
        .verdict        (verdict)
    );
endmodule

// ===== test/fwcrc_tb_pkg.sv =====
`timescale 1ns / 100ps
// Bit-serial CRC-32 byte step shared by the verifier testbench and its checker.
// Depends on fwcrc_pkg for the polynomial.
package fwcrc_tb_pkg;
    import fwcrc_pkg::*;

    function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc,
                                                  input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'h0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== test/fwcrc_checker.sv =====
`timescale 1ns / 100ps
// Checker for the firmware image CRC verifier: predicts verdicts from the accepted
// requests and register writes, and compares them with the verdicts that leave the block.
// Depends on fwcrc_pkg, fwcrc_tb_pkg and the two channel interfaces.
module fwcrc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    fwcrc_in_if         item,
    fwcrc_out_if        verdict,
    output int          fail_count,
    output int          waiting,
    output int          verdicts_checked
);
    import fwcrc_pkg::*;
    import fwcrc_tb_pkg::*;

    typedef struct packed {
        status_t     status;
        logic        discard_header;
        logic [31:0] computed_crc;
    } verdict_t;

    verdict_t         verdict_q[$];
    logic [31:0]      magic_reg;
    logic             armed;
    logic [31:0]      crc_run;
    logic [CNT_W-1:0] byte_count;
    logic [CNT_W-1:0] image_len;
    logic [31:0]      crc_claim;

    task automatic fold_request();
        logic [31:0] final_crc;
        if (item.opcode == OP_START) begin
            // Any image in progress is dropped by a new header.
            armed = 1'b0;
            if (item.header_magic != magic_reg) begin
                verdict_q.push_back(verdict_t'{ST_NO_REQUEST, 1'b0, 32'h0});
            end
            else if (item.image_size == 32'h0 || item.image_size > REGION_LIMIT) begin
                verdict_q.push_back(verdict_t'{ST_SIZE_ERROR, 1'b0, 32'h0});
            end
            else begin
                armed      = 1'b1;
                crc_run    = CRC_ALL_ONES;
                byte_count = '0;
                image_len  = item.image_size[CNT_W-1:0];
                crc_claim  = item.expected_crc;
            end
        end
        else if (armed) begin
            crc_run    = crc_fold_byte(crc_run, item.data_byte);
            byte_count = byte_count + 1'b1;
            if (byte_count >= image_len) begin
                armed     = 1'b0;
                final_crc = crc_run ^ CRC_ALL_ONES;
                if (final_crc == crc_claim) begin
                    verdict_q.push_back(verdict_t'{ST_OK, 1'b0, final_crc});
                end
                else begin
                    verdict_q.push_back(verdict_t'{ST_CRC_FAIL, 1'b1, final_crc});
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : predict_and_compare
        verdict_t want;
        if (!rst_n) begin
            verdict_q.delete();
            magic_reg        = 32'h0;
            armed            = 1'b0;
            crc_run          = CRC_ALL_ONES;
            byte_count       = '0;
            image_len        = '0;
            crc_claim        = 32'h0;
            fail_count       = 0;
            waiting          = 0;
            verdicts_checked = 0;
        end
        else begin
            if (verdict.valid && verdict.ready) begin
                verdicts_checked++;
                if (verdict_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: unexpected verdict status %s discard %0b crc %08h",
                                 $realtime, verdict.status.name(), verdict.discard_header,
                                 verdict.computed_crc);
                    end
                end
                else begin
                    want = verdict_q.pop_front();
                    if (verdict.status !== want.status
                            || verdict.discard_header !== want.discard_header
                            || verdict.computed_crc !== want.computed_crc) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: verdict mismatch: expected %s/%0b/%08h, got %s/%0b/%08h",
                                     $realtime, want.status.name(), want.discard_header,
                                     want.computed_crc, verdict.status.name(),
                                     verdict.discard_header, verdict.computed_crc);
                        end
                    end
                end
            end
            if (cfg_wr_en) begin
                magic_reg = cfg_wr_data;
            end
            if (item.valid && item.ready) begin
                fold_request();
            end
            waiting = verdict_q.size();
        end
    end

endmodule

// ===== test/tb_firmware_image_crc_verifier.sv =====
`timescale 1ns / 100ps
// Testbench top for the firmware image CRC verifier: drives headers and image bytes,
// changes the magic word between phases, varies handshake load and reports the verdict.
// Depends on fwcrc_pkg, fwcrc_tb_pkg, the channel interfaces and fwcrc_checker.
module tb_firmware_image_crc_verifier;
    import fwcrc_pkg::*;
    import fwcrc_tb_pkg::*;

    typedef logic [7:0] image_bytes_t[$];

    localparam int REQUESTS_PER_PHASE = 480;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    int          fail_count;
    int          waiting;
    int          verdicts_checked;
    int          gap_pct   = 0;
    int          stall_pct = 0;
    int          req_count = 0;
    int          image_count = 0;
    int          broken_count = 0;
    logic [31:0] cur_magic;

    fwcrc_in_if  item_ch ();
    fwcrc_out_if verdict_ch ();

    firmware_image_crc_verifier u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .verdict     (verdict_ch)
    );

    fwcrc_checker u_chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .item             (item_ch),
        .verdict          (verdict_ch),
        .fail_count       (fail_count),
        .waiting          (waiting),
        .verdicts_checked (verdicts_checked)
    );

    always #10 clk = ~clk;

    initial begin : verdict_receiver
        verdict_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            verdict_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin : watchdog
        #12_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Valid stays high after acceptance; the next call either idles or presents
    // the next request, so valid is never lowered and raised in one step.
    task automatic push(input item_t req);
        while ($urandom_range(99) < gap_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.opcode       <= req.opcode;
        item_ch.header_magic <= req.header_magic;
        item_ch.image_size   <= req.image_size;
        item_ch.expected_crc <= req.expected_crc;
        item_ch.data_byte    <= req.data_byte;
        do @(posedge clk); while (!item_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_start(input logic [31:0] magic, input logic [31:0] size,
                              input logic [31:0] claim);
        push(item_t'{OP_START, magic, size, claim, 8'($urandom)});
        req_count++;
    endtask

    task automatic send_byte(input logic [7:0] data);
        push(item_t'{OP_DATA, 32'($urandom), 32'($urandom), 32'($urandom), data});
    endtask

    task automatic send_image(input image_bytes_t data, input logic [31:0] claim,
                              input int n_send);
        send_start(cur_magic, 32'(data.size()), claim);
        for (int i = 0; i < n_send; i++) begin
            send_byte(data[i]);
        end
        req_count += n_send;
    endtask

    function automatic image_bytes_t random_image(input int len);
        image_bytes_t data;
        for (int i = 0; i < len; i++) begin
            data.push_back(8'($urandom));
        end
        return data;
    endfunction

    function automatic logic [31:0] image_crc(input image_bytes_t data);
        logic [31:0] crc;
        crc = CRC_ALL_ONES;
        foreach (data[i]) begin
            crc = crc_fold_byte(crc, data[i]);
        end
        return crc ^ CRC_ALL_ONES;
    endfunction

    // Waits until every predicted verdict is out, then lets in-flight data bytes settle.
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(negedge clk);
        while (waiting != 0) begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_magic(input logic [31:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cur_magic = value;
    endtask

    task automatic random_request();
        image_bytes_t data;
        logic [31:0]  crc;
        logic [31:0]  size;
        int unsigned  pick;
        int           len;
        pick = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? $urandom_range(300, 17) : $urandom_range(16, 1);
        data = random_image(len);
        crc  = image_crc(data);
        if (pick < 55) begin
            send_image(data, crc, len);
            image_count++;
        end
        else if (pick < 70) begin
            // Setting bit 0 of the mask keeps the claimed CRC different from the real one.
            send_image(data, crc ^ (32'($urandom) | 32'h1), len);
            image_count++;
        end
        else if (pick < 78) begin
            send_image(data, crc, $urandom_range(len - 1, 0));
            broken_count++;
        end
        else if (pick < 86) begin
            if ($urandom_range(1) == 1) begin
                send_start(cur_magic ^ (32'h1 << $urandom_range(31)), 32'(len), crc);
            end
            else begin
                send_start(32'($urandom), 32'(len), crc);
            end
            broken_count++;
        end
        else if (pick < 93) begin
            case ($urandom_range(4))
                0:       size = 32'h0;
                1:       size = REGION_LIMIT + 32'h1;
                2:       size = 32'hFFFF_FFFF;
                3:       size = REGION_LIMIT;
                default: size = 32'($urandom) | 32'h0002_0000;
            endcase
            send_start(cur_magic, size, 32'($urandom));
            broken_count++;
        end
        else begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
        end
    endtask

    initial begin : stimulus
        image_bytes_t check_str;
        image_bytes_t one_byte;
        logic [31:0]  phase_magic [4];
        int           phase_end;

        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = 32'h0;
        item_ch.valid        = 1'b0;
        item_ch.opcode       = OP_START;
        item_ch.header_magic = 32'h0;
        item_ch.image_size   = 32'h0;
        item_ch.expected_crc = 32'h0;
        item_ch.data_byte    = 8'h0;
        cur_magic            = 32'h0;
        phase_magic[0]       = 32'hFFFF_FFFF;
        phase_magic[1]       = 32'($urandom);
        phase_magic[2]       = 32'($urandom);
        phase_magic[3]       = 32'h0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, run with the magic word still at its reset value.
        send_byte(8'hFF);
        send_start(32'h0000_0001, 32'd16, 32'h0);
        send_start(cur_magic, 32'h0, 32'h0);
        send_start(cur_magic, REGION_LIMIT + 32'h1, 32'h0);
        send_start(cur_magic, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
        send_image(check_str, 32'hCBF4_3926, 9);
        one_byte = '{8'h00};
        send_image(one_byte, 32'h0, 1);
        send_image('{8'hFF, 8'hFF}, 32'hFFFF_FFFF, 2);
        // An image cut short by a fresh header, which must then verify on its own.
        send_image(random_image(4), 32'($urandom), 2);
        one_byte = '{8'h80};
        send_image(one_byte, image_crc(one_byte), 1);
        image_count += 4;
        broken_count++;

        for (int ph = 0; ph < 4; ph++) begin
            write_magic(phase_magic[ph]);
            case (ph)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 59; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 59; end
                default: begin gap_pct = 10; stall_pct = 10; end
            endcase
            phase_end = req_count + REQUESTS_PER_PHASE;
            while (req_count < phase_end) begin
                random_request();
            end
        end

        drain();
        $display("Sent %0d requests: %0d whole images, %0d cut or rejected headers,",
                 req_count, image_count, broken_count);
        $display("over four handshake load patterns and five magic words; %0d verdicts checked.",
                 verdicts_checked);
        if (fail_count == 0 && waiting == 0) begin
            $display("Test completed successfully");
        end
        else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
